[sv/dhpc_pkg.sv]
// Types, constants and target tables shared by the puff controller modules.
package dhpc_pkg;

   localparam int VBAT_W     = 10;
   localparam int GEAR_W     = 2;
   localparam int DUTY_W     = 7;
   localparam int DIVIDEND_W = 16;
   localparam int QUO_BITS   = 7;
   localparam int CNT_W      = 3;

   localparam logic [GEAR_W-1:0] GEAR_RESET    = 2'd2;
   localparam logic [1:0]        RELEASE_TICKS = 2'd3;
   localparam logic [DUTY_W-1:0] DUTY_FULL     = 7'd100;
   localparam logic [DUTY_W-1:0] DUTY_OFF      = 7'd0;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_DIV_A = 4'b0010,
      ST_DIV_B = 4'b0100,
      ST_DONE  = 4'b1000
   } dhpc_state_type;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [VBAT_W-1:0]     divisor;
   } dhpc_div_req_type;

   typedef struct packed {
      logic                done;
      logic [QUO_BITS-1:0] quotient;
   } dhpc_div_rsp_type;

   function automatic logic [VBAT_W-1:0] target_a(input logic [GEAR_W-1:0] gear);
      logic [VBAT_W-1:0] t;
      unique case (gear)
         2'd1:    t = 10'd210;
         2'd2:    t = 10'd280;
         2'd3:    t = 10'd350;
         default: t = 10'd0;
      endcase
      return t;
   endfunction

   function automatic logic [VBAT_W-1:0] target_b(input logic [GEAR_W-1:0] gear);
      logic [VBAT_W-1:0] t;
      unique case (gear)
         2'd1:    t = 10'd210;
         2'd2:    t = 10'd240;
         2'd3:    t = 10'd270;
         default: t = 10'd0;
      endcase
      return t;
   endfunction

   function automatic logic [DIVIDEND_W-1:0] product_a(input logic [GEAR_W-1:0] gear);
      logic [DIVIDEND_W-1:0] p;
      unique case (gear)
         2'd1:    p = 16'd21000;
         2'd2:    p = 16'd28000;
         2'd3:    p = 16'd35000;
         default: p = 16'd0;
      endcase
      return p;
   endfunction

   function automatic logic [DIVIDEND_W-1:0] product_b(input logic [GEAR_W-1:0] gear);
      logic [DIVIDEND_W-1:0] p;
      unique case (gear)
         2'd1:    p = 16'd21000;
         2'd2:    p = 16'd24000;
         2'd3:    p = 16'd27000;
         default: p = 16'd0;
      endcase
      return p;
   endfunction

   function automatic logic [DUTY_W-1:0] duty_pick(
      input logic [VBAT_W-1:0]   target,
      input logic [VBAT_W-1:0]   vbat,
      input logic [QUO_BITS-1:0] quotient
   );
      logic [DUTY_W-1:0] d;
      priority if (target == '0) begin
         d = DUTY_OFF;
      end else if (vbat <= target) begin
         d = DUTY_FULL;
      end else begin
         d = quotient;
      end
      return d;
   endfunction

endpackage

[sv/dhpc_req_if.sv]
// Tick input channel: valid/ready handshake with sensor and battery payload.
interface dhpc_req_if import dhpc_pkg::*;;
   logic              valid;
   logic              ready;
   logic              mic_level;
   logic [VBAT_W-1:0] vbat;
   logic              battery_empty;

   modport source (output valid, output mic_level, output vbat, output battery_empty,
                   input ready);
   modport sink   (input valid, input mic_level, input vbat, input battery_empty,
                   output ready);
endinterface

[sv/dhpc_rsp_if.sv]
// Result channel: valid/ready handshake with heater duties and puff status.
interface dhpc_rsp_if import dhpc_pkg::*;;
   logic              valid;
   logic              ready;
   logic [DUTY_W-1:0] duty_first;
   logic [DUTY_W-1:0] duty_second;
   logic              firing;
   logic              start_refused;

   modport source (output valid, output duty_first, output duty_second, output firing,
                   output start_refused, input ready);
   modport sink   (input valid, input duty_first, input duty_second, input firing,
                   input start_refused, output ready);
endinterface

[sv/dhpc_div.sv]
// Restoring divider, one quotient bit per cycle, shared by both heater duties.
module dhpc_div import dhpc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  dhpc_div_req_type div_req,
   output dhpc_div_rsp_type div_rsp
);

   logic [DIVIDEND_W-1:0] rem_ff, rem_in;
   logic [VBAT_W-1:0]     dsr_ff, dsr_in;
   logic [QUO_BITS-1:0]   quo_ff, quo_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIVIDEND_W:0]   shifted;
   logic                  fits;

   always_comb begin
      shifted = {{(DIVIDEND_W+1-VBAT_W){1'b0}}, dsr_ff} << cnt_ff;
      fits    = {1'b0, rem_ff} >= shifted;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in  = div_req.dividend;
         dsr_in  = div_req.divisor;
         quo_in  = '0;
         cnt_in  = CNT_W'(QUO_BITS - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[QUO_BITS-2:0], fits};
         if (fits) begin
            rem_in = rem_ff - shifted[DIVIDEND_W-1:0];
         end
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

[sv/dual_heater_puff_controller.sv]
// Dual heater puff controller: release qualifier, fire machine and duty sequencer.
//
//  channel  direction  handshake              payload
//  req_if   in         valid/ready            mic_level, vbat, battery_empty
//  rsp_if   out        valid/ready            duty_first, duty_second, firing,
//                                             start_refused
//  csr_*    in         csr_we, no wait        csr_wdata = gear
//
// A tick with no active firing goes from ST_IDLE through ST_DONE to the result register.
// A firing tick also passes ST_DIV_A and ST_DIV_B: two passes through the one divider.
// The next tick is taken while the previous result still waits in its register.
// Synchronous reset clears the qualifier, the fire machine and gear (to 2).
// A stalled result channel holds the sequencer in its final state.
module dual_heater_puff_controller import dhpc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   dhpc_req_if.sink          req_if,
   dhpc_rsp_if.source        rsp_if,
   input  logic              csr_we,
   input  logic [GEAR_W-1:0] csr_wdata
);

   dhpc_state_type    state_ff, state_in;
   logic [GEAR_W-1:0] gear_ff, gear_in;
   logic              latched_ff, latched_in;
   logic [1:0]        low_cnt_ff, low_cnt_in;
   logic              fire_ff, fire_in;
   logic              swap_ff, swap_in;
   logic              compute_ff, compute_in;
   logic              refused_ff, refused_in;
   logic [VBAT_W-1:0] vbat_ff, vbat_in;
   logic [DUTY_W-1:0] pa_ff, pa_in;
   logic [DUTY_W-1:0] pb_ff, pb_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [DUTY_W-1:0] rsp_first_ff, rsp_first_in;
   logic [DUTY_W-1:0] rsp_second_ff, rsp_second_in;
   logic              rsp_firing_ff, rsp_firing_in;
   logic              rsp_refused_ff, rsp_refused_in;

   logic              accept;
   logic              detect;
   logic [1:0]        low_next;
   logic              load_rsp;
   dhpc_div_req_type  div_req;
   dhpc_div_rsp_type  div_rsp;

   dhpc_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_if.ready = (state_ff == ST_IDLE);
   assign accept       = req_if.valid && req_if.ready;

   always_comb begin
      gear_in        = csr_we ? csr_wdata : gear_ff;
      state_in       = state_ff;
      latched_in     = latched_ff;
      low_cnt_in     = low_cnt_ff;
      fire_in        = fire_ff;
      swap_in        = swap_ff;
      compute_in     = compute_ff;
      refused_in     = refused_ff;
      vbat_in        = vbat_ff;
      pa_in          = pa_ff;
      pb_in          = pb_ff;
      detect         = 1'b0;
      low_next       = low_cnt_ff + 1'b1;
      load_rsp       = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = product_a(gear_ff);
      div_req.divisor  = req_if.vbat;
      rsp_first_in   = rsp_first_ff;
      rsp_second_in  = rsp_second_ff;
      rsp_firing_in  = rsp_firing_ff;
      rsp_refused_in = rsp_refused_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               // release qualifier
               if (!latched_ff) begin
                  if (req_if.mic_level) begin
                     detect     = 1'b1;
                     latched_in = 1'b1;
                     low_cnt_in = '0;
                  end
               end else begin
                  detect = 1'b1;
                  if (!req_if.mic_level) begin
                     if (low_next == RELEASE_TICKS) begin
                        detect     = 1'b0;
                        low_cnt_in = '0;
                        latched_in = 1'b0;
                     end else begin
                        low_cnt_in = low_next;
                     end
                  end
               end
               // fire machine
               refused_in = 1'b0;
               compute_in = 1'b0;
               if (!fire_ff) begin
                  if (detect) begin
                     if (req_if.battery_empty) begin
                        refused_in = 1'b1;
                     end else begin
                        fire_in = 1'b1;
                        swap_in = !swap_ff;
                     end
                  end
               end else if (detect) begin
                  compute_in = 1'b1;
               end else begin
                  fire_in = 1'b0;
               end
               vbat_in = req_if.vbat;
               if (fire_ff && detect) begin
                  div_req.start = 1'b1;
                  state_in      = ST_DIV_A;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DIV_A: begin
            div_req.dividend = product_b(gear_ff);
            div_req.divisor  = vbat_ff;
            if (div_rsp.done) begin
               pa_in         = duty_pick(target_a(gear_ff), vbat_ff, div_rsp.quotient);
               div_req.start = 1'b1;
               state_in      = ST_DIV_B;
            end
         end
         ST_DIV_B: begin
            if (div_rsp.done) begin
               pb_in    = duty_pick(target_b(gear_ff), vbat_ff, div_rsp.quotient);
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               load_rsp       = 1'b1;
               rsp_first_in   = compute_ff ? (swap_ff ? pa_ff : pb_ff) : DUTY_OFF;
               rsp_second_in  = compute_ff ? (swap_ff ? pb_ff : pa_ff) : DUTY_OFF;
               rsp_firing_in  = fire_ff;
               rsp_refused_in = refused_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      compute_ff     <= compute_in;
      refused_ff     <= refused_in;
      vbat_ff        <= vbat_in;
      pa_ff          <= pa_in;
      pb_ff          <= pb_in;
      rsp_first_ff   <= rsp_first_in;
      rsp_second_ff  <= rsp_second_in;
      rsp_firing_ff  <= rsp_firing_in;
      rsp_refused_ff <= rsp_refused_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         gear_ff      <= GEAR_RESET;
         latched_ff   <= 1'b0;
         low_cnt_ff   <= '0;
         fire_ff      <= 1'b0;
         swap_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gear_ff      <= gear_in;
         latched_ff   <= latched_in;
         low_cnt_ff   <= low_cnt_in;
         fire_ff      <= fire_in;
         swap_ff      <= swap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.duty_first    = rsp_first_ff;
   assign rsp_if.duty_second   = rsp_second_ff;
   assign rsp_if.firing        = rsp_firing_ff;
   assign rsp_if.start_refused = rsp_refused_ff;

   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_first_ff <= DUTY_FULL) && (rsp_second_ff <= DUTY_FULL))
      else $error("duty above full scale");

   a_idle_no_duty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_firing_ff) |-> (rsp_first_ff == '0) && (rsp_second_ff == '0))
      else $error("duty driven while not firing");

   a_refused_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_refused_ff && rsp_firing_ff))
      else $error("refused start reported while firing");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_DIV_A) || (state_ff == ST_DIV_B))
      else $error("divider result outside a divide state");

   a_low_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      low_cnt_ff != RELEASE_TICKS)
      else $error("low tick count reached release without clearing");

endmodule

[sim/testbench.sv]
// Self-checking testbench for the dual heater puff controller: directed and random ticks.
`timescale 1ns / 100ps

module testbench;
   import dhpc_pkg::*;

   localparam int STALL_LIMIT = 5000;
   localparam int HOLD_LEN    = 400;
   localparam int PHASE_TICKS = 560;

   typedef struct packed {
      logic [DUTY_W-1:0] duty_first;
      logic [DUTY_W-1:0] duty_second;
      logic              firing;
      logic              start_refused;
   } heater_out_type;

   logic              clock;
   logic              reset;
   logic              csr_we;
   logic [GEAR_W-1:0] csr_wdata;

   dhpc_req_if req_if ();
   dhpc_rsp_if rsp_if ();

   dual_heater_puff_controller DUT (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // predicted controller state
   logic              qual_latched    = 1'b0;
   logic [1:0]        qual_lows       = 2'd0;
   logic              fire_on         = 1'b0;
   logic              heaters_swapped = 1'b0;
   logic [GEAR_W-1:0] gear_now        = GEAR_RESET;

   int curve_a_tgt [4] = '{0, 210, 280, 350};
   int curve_b_tgt [4] = '{0, 210, 240, 270};

   heater_out_type heater_queue [$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_requests = 0;
   int hold_seen     = 0;
   int hold_left     = 0;
   int ticks_sent    = 0;
   int results_seen  = 0;
   int errors        = 0;
   int stall_cycles  = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int duty_percent(input int target, input int v);
      if (target == 0) return 0;
      if (v <= target) return 100;
      return (target * 100) / v;
   endfunction

   function automatic heater_out_type predict_heater_output(input logic mic,
                                                             input logic [VBAT_W-1:0] v,
                                                             input logic empty);
      heater_out_type r;
      logic           detect;
      int             pa;
      int             pb;
      r = '0;
      if (!qual_latched) begin
         detect = mic;
         if (mic) begin
            qual_latched = 1'b1;
            qual_lows    = 2'd0;
         end
      end else begin
         detect = 1'b1;
         if (!mic) begin
            qual_lows = qual_lows + 2'd1;
            if (qual_lows == RELEASE_TICKS) begin
               detect       = 1'b0;
               qual_lows    = 2'd0;
               qual_latched = 1'b0;
            end
         end
      end
      if (!fire_on) begin
         if (detect) begin
            if (empty) begin
               r.start_refused = 1'b1;
            end else begin
               fire_on         = 1'b1;
               heaters_swapped = ~heaters_swapped;
            end
         end
      end else if (detect) begin
         pa = duty_percent(curve_a_tgt[gear_now], int'(v));
         pb = duty_percent(curve_b_tgt[gear_now], int'(v));
         r.duty_first  = heaters_swapped ? DUTY_W'(pa) : DUTY_W'(pb);
         r.duty_second = heaters_swapped ? DUTY_W'(pb) : DUTY_W'(pa);
      end else begin
         fire_on = 1'b0;
      end
      r.firing = fire_on;
      return r;
   endfunction

   function automatic logic [VBAT_W-1:0] pick_vbat();
      unique case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2, 3, 4, 5: return VBAT_W'($urandom_range(180, 380));
         default: return VBAT_W'($urandom_range(0, 1023));
      endcase
   endfunction

   task automatic send_tick(input logic mic, input logic [VBAT_W-1:0] v, input logic empty);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_if.valid = 1'b0;
         @(negedge clock);
      end
      req_if.valid         = 1'b1;
      req_if.mic_level     = mic;
      req_if.vbat          = v;
      req_if.battery_empty = empty;
      do @(posedge clock); while (!req_if.ready);
      heater_queue.push_back(predict_heater_output(mic, v, empty));
      ticks_sent++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_if.valid = 1'b0;
      while (heater_queue.size() != 0) @(posedge clock);
      repeat (24) @(posedge clock);
   endtask

   task automatic set_gear(input logic [GEAR_W-1:0] g);
      wait_drained();
      @(negedge clock);
      csr_we    = 1'b1;
      csr_wdata = g;
      @(negedge clock);
      csr_we   = 1'b0;
      gear_now = g;
   endtask

   task automatic random_puff();
      int highs;
      int lows;
      highs = $urandom_range(1, 14);
      lows  = 3 + $urandom_range(0, 3);
      for (int i = 0; i < highs; i++) begin
         send_tick(1'b1, pick_vbat(), $urandom_range(0, 99) < 10);
         if ($urandom_range(0, 99) < 25) begin
            repeat ($urandom_range(1, 2)) send_tick(1'b0, pick_vbat(),
                                                    1'($urandom_range(0, 1)));
         end
      end
      repeat (lows) send_tick(1'b0, pick_vbat(), $urandom_range(0, 99) < 10);
   endtask

   task automatic random_noise();
      repeat ($urandom_range(1, 8)) send_tick(1'($urandom_range(0, 1)), VBAT_W'($urandom),
                                              1'($urandom_range(0, 1)));
   endtask

   task automatic run_random_ticks(input int count);
      int stop_at;
      stop_at = ticks_sent + count;
      while (ticks_sent < stop_at) begin
         if ($urandom_range(0, 99) < 85) random_puff();
         else random_noise();
      end
   endtask

   task automatic test_release_qualifier();
      send_tick(1'b0, 10'd300, 1'b0);
      send_tick(1'b1, 10'd300, 1'b0);
      send_tick(1'b1, 10'd280, 1'b0);
      send_tick(1'b0, 10'd300, 1'b0);
      // high while latched keeps the low count
      send_tick(1'b1, 10'd1023, 1'b0);
      send_tick(1'b0, 10'd400, 1'b0);
      send_tick(1'b0, 10'd400, 1'b0);
      send_tick(1'b0, 10'd400, 1'b0);
   endtask

   task automatic test_refused_start();
      send_tick(1'b1, 10'd350, 1'b1);
      send_tick(1'b1, 10'd350, 1'b1);
      send_tick(1'b0, 10'd350, 1'b1);
      send_tick(1'b0, 10'd350, 1'b0);
      send_tick(1'b0, 10'd350, 1'b0);
   endtask

   task automatic test_duty_extremes();
      set_gear(2'd3);
      send_tick(1'b1, 10'd500, 1'b0);
      send_tick(1'b1, 10'd0, 1'b0);
      send_tick(1'b1, 10'd270, 1'b0);
      send_tick(1'b1, 10'd351, 1'b0);
      send_tick(1'b1, 10'd1023, 1'b0);
      repeat (3) send_tick(1'b0, 10'd280, 1'b0);
   endtask

   task automatic test_gear_zero();
      set_gear(2'd0);
      send_tick(1'b1, 10'd500, 1'b0);
      send_tick(1'b1, 10'd100, 1'b0);
      repeat (3) send_tick(1'b0, 10'd500, 1'b0);
   endtask

   task automatic test_random_ticks();
      set_gear(2'd1);
      send_idle_pct = 6;
      recv_idle_pct = 69;
      run_random_ticks(PHASE_TICKS);
      set_gear(2'd3);
      send_idle_pct = 69;
      recv_idle_pct = 6;
      run_random_ticks(PHASE_TICKS);
      set_gear(2'd2);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random_ticks(PHASE_TICKS);
   endtask

   task automatic test_result_backpressure();
      set_gear(2'd3);
      @(posedge clock);
      hold_requests++;
      run_random_ticks(40);
      wait_drained();
   endtask

   task automatic check_field(input string name, input logic [DUTY_W-1:0] want,
                              input logic [DUTY_W-1:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = HOLD_LEN;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready = 1'b0;
         end else begin
            rsp_if.ready = ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      heater_out_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (heater_queue.size() == 0) begin
            errors++;
            $display("%0t: result with no tick pending: %0d %0d %0b %0b", $time,
                     rsp_if.duty_first, rsp_if.duty_second, rsp_if.firing,
                     rsp_if.start_refused);
         end else begin
            want = heater_queue.pop_front();
            check_field("duty_first", want.duty_first, rsp_if.duty_first);
            check_field("duty_second", want.duty_second, rsp_if.duty_second);
            check_field("firing", DUTY_W'(want.firing), DUTY_W'(rsp_if.firing));
            check_field("start_refused", DUTY_W'(want.start_refused),
                        DUTY_W'(rsp_if.start_refused));
            results_seen++;
         end
      end
   end

   initial begin
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) stall_cycles = 0;
         else stall_cycles++;
      end
      $display("%0t: no transfer for %0d cycles, %0d results outstanding", $time,
               STALL_LIMIT, heater_queue.size());
      $display("FAILURE");
      $finish;
   end

   initial begin
      reset                = 1'b1;
      csr_we               = 1'b0;
      csr_wdata            = GEAR_RESET;
      req_if.valid         = 1'b0;
      req_if.mic_level     = 1'b0;
      req_if.vbat          = '0;
      req_if.battery_empty = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_release_qualifier();
      test_refused_start();
      test_duty_extremes();
      test_gear_zero();
      test_random_ticks();
      test_result_backpressure();

      $display("Run covered puff release, refused starts, duty limits, gears 0 to 3, both");
      $display("idle patterns and a long result stall: %0d ticks, %0d results, %0d errors",
               ticks_sent, results_seen, errors);
      if (errors == 0 && heater_queue.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
